[hdl/evi_pkg.sv]
// Shared constants and types for the eased view interpolator.
// Used by evi_mul_unit and eased_view_interpolator_unit; no dependencies.
`default_nettype none

package evi_pkg;

  // Fixed-point constants (Q0.16 / Q16.16)
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  // Elapsed time counter
  localparam int unsigned ElapsedW = 25;
  localparam logic [ElapsedW-1:0] ELAPSED_MAX = {ElapsedW{1'b1}};

  // Duration register
  localparam int unsigned DurW = 24;
  localparam logic [DurW-1:0] DUR_RESET = 24'd500000;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_X_ENDS      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_Y_ENDS      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_ENDS  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_START_SCALE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PEAK_SCALE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_END_SCALE   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DURATION    = 3'd6;

  // Shared multiplier operand widths
  localparam int unsigned MulAW   = 34;
  localparam int unsigned MulBW   = 18;
  localparam int unsigned MulProdW = MulAW + MulBW;

  // Request to the shared multiplier
  typedef struct packed {
    logic                     en;
    logic signed [MulAW-1:0]  op_a;
    logic signed [MulBW-1:0]  op_b;
  } mul_req_t;

endpackage

`default_nettype wire

[hdl/eased_view_interpolator_unit.sv]
// Eased view interpolator: quartic ease-out of elapsed/duration, linear x/y/angle, scale via peak.
// Per request: 1 prepare, 17 divide steps, 7 multiply/add steps, 1 output load (held while
// the output is stalled); a new request is taken only once the sequencer is back in idle,
// as the restoring divider and the single shared multiplier (evi_mul_unit) are reused.
// Reset (rst_ni low, asynchronous): elapsed time cleared, registers to their defaults,
// output empty, sequencer idle.
`default_nettype none

module eased_view_interpolator_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [evi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]                 cfg_data_i,
  // input requests
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [23:0]                 s_axis_tdata_i,  // delta_us[19:0], zero pad
  input  wire logic [0:0]                  s_axis_tuser_i,  // opcode[0]
  // result requests
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // pos_x[31:0], pos_y[63:32], cur_scale[95:64], cur_angle[127:96], eased_t[144:128], pad
  output logic [151:0]                     m_axis_tdata_o,
  output logic [1:0]                       m_axis_tuser_o   // finished[0], angle_valid[1]
);
  import evi_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_SQ1  = 4'd3;
  localparam logic [3:0] S_SQ2  = 4'd4;
  localparam logic [3:0] S_EASE = 4'd5;
  localparam logic [3:0] S_LX   = 4'd6;
  localparam logic [3:0] S_LY   = 4'd7;
  localparam logic [3:0] S_LA   = 4'd8;
  localparam logic [3:0] S_LS   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam logic [4:0] DIV_LAST = 5'd16;

  // Configuration registers
  logic [63:0]     x_ends_q, y_ends_q, angle_ends_q;
  logic [31:0]     start_scale_q, peak_scale_q, end_scale_q;
  logic [DurW-1:0] duration_q;

  // Control and working registers
  logic [3:0]          state_q, state_d;
  logic [ElapsedW-1:0] elapsed_q;
  logic                fin_q;
  logic [ElapsedW-1:0] rem_q;
  logic [16:0]         quo_q;
  logic [4:0]          cnt_q;
  logic [16:0]         e_q;
  logic [31:0]         px_q, py_q, pa_q;
  logic                out_valid_q;
  logic [151:0]        out_data_q;
  logic [1:0]          out_user_q;

  // Shared multiplier
  mul_req_t                mreq;
  logic signed [MulAW-1:0] mres;

  evi_mul_unit u_mul (
    .clk_i (clk_i),
    .req_i (mreq),
    .res_o (mres)
  );

  // Effective duration, never zero
  logic [DurW-1:0] dur_eff;
  assign dur_eff = (duration_q == '0) ? DurW'(1) : duration_q;

  // Elapsed time update on accept
  logic                in_acc;
  logic [ElapsedW:0]   el_sum;
  logic [ElapsedW-1:0] el_new;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    el_sum = {1'b0, elapsed_q} + (ElapsedW+1)'(s_axis_tdata_i[19:0]);
    if (s_axis_tuser_i[0]) begin
      el_new = {1'b0, dur_eff} + ElapsedW'(1);
    end else if (el_sum[ElapsedW]) begin
      el_new = ELAPSED_MAX;
    end else begin
      el_new = el_sum[ElapsedW-1:0];
    end
  end

  // Restoring divide step: one quotient bit per cycle
  logic [ElapsedW:0]   div_diff;
  logic                div_ge;
  logic [ElapsedW-1:0] div_rn;

  always_comb begin
    div_diff = {1'b0, rem_q} - {2'b0, dur_eff};
    div_ge   = !div_diff[ElapsedW];
    div_rn   = div_ge ? div_diff[ElapsedW-1:0] : rem_q;
  end

  // Ease and interpolation operands
  logic [16:0]             u_val;
  logic [16:0]             u2_val;
  logic                    sc_hi;
  logic [16:0]             sc_frac;
  logic [16:0]             e_off;
  logic signed [MulAW-1:0] dx, dy, da, ds;
  logic signed [MulAW-1:0] ax_ext, ay_ext, aa_ext, as_ext;
  logic [31:0]             sc_a, sc_b;

  always_comb begin
    u_val   = fin_q ? 17'd0 : (ONE_Q16 - quo_q);
    u2_val  = mres[16:0];
    sc_hi   = (e_q > HALF_Q16);
    e_off   = e_q - HALF_Q16;
    sc_frac = sc_hi ? {e_off[15:0], 1'b0} : {e_q[15:0], 1'b0};
    sc_a    = sc_hi ? peak_scale_q : start_scale_q;
    sc_b    = sc_hi ? end_scale_q : peak_scale_q;
    ax_ext  = MulAW'($signed(x_ends_q[31:0]));
    ay_ext  = MulAW'($signed(y_ends_q[31:0]));
    aa_ext  = MulAW'($signed(angle_ends_q[31:0]));
    as_ext  = $signed({2'b00, sc_a});
    dx      = MulAW'($signed(x_ends_q[63:32])) - ax_ext;
    dy      = MulAW'($signed(y_ends_q[63:32])) - ay_ext;
    da      = MulAW'($signed(angle_ends_q[63:32])) - aa_ext;
    ds      = $signed({2'b00, sc_b}) - as_ext;
  end

  // Multiplier operand selection per step
  always_comb begin
    mreq.en   = 1'b0;
    mreq.op_a = '0;
    mreq.op_b = '0;
    case (state_q)
      S_SQ1: begin
        mreq.en   = 1'b1;
        mreq.op_a = $signed({17'd0, u_val});
        mreq.op_b = $signed({1'b0, u_val});
      end
      S_SQ2: begin
        mreq.en   = 1'b1;
        mreq.op_a = $signed({17'd0, u2_val});
        mreq.op_b = $signed({1'b0, u2_val});
      end
      S_LX: begin
        mreq.en   = 1'b1;
        mreq.op_a = dx;
        mreq.op_b = $signed({1'b0, e_q});
      end
      S_LY: begin
        mreq.en   = 1'b1;
        mreq.op_a = dy;
        mreq.op_b = $signed({1'b0, e_q});
      end
      S_LA: begin
        mreq.en   = 1'b1;
        mreq.op_a = da;
        mreq.op_b = $signed({1'b0, e_q});
      end
      S_LS: begin
        mreq.en   = 1'b1;
        mreq.op_a = ds;
        mreq.op_b = $signed({1'b0, sc_frac});
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  // Output register can take a new result
  logic out_free;
  logic signed [MulAW-1:0] lerp_sum;
  logic signed [MulAW-1:0] lerp_base;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    case (state_q)
      S_LY:    lerp_base = ax_ext;
      S_LA:    lerp_base = ay_ext;
      S_LS:    lerp_base = aa_ext;
      default: lerp_base = as_ext;
    endcase
    lerp_sum = lerp_base + mres;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_PREP;
      S_PREP:  state_d = S_DIV;
      S_DIV:   if (cnt_q == DIV_LAST) state_d = S_SQ1;
      S_SQ1:   state_d = S_SQ2;
      S_SQ2:   state_d = S_EASE;
      S_EASE:  state_d = S_LX;
      S_LX:    state_d = S_LY;
      S_LY:    state_d = S_LA;
      S_LA:    state_d = S_LS;
      S_LS:    state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_ends_q      <= '0;
      y_ends_q      <= '0;
      angle_ends_q  <= '0;
      start_scale_q <= 32'(ONE_Q16);
      peak_scale_q  <= 32'(ONE_Q16);
      end_scale_q   <= 32'(ONE_Q16);
      duration_q    <= DUR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_ENDS:      x_ends_q      <= cfg_data_i;
        REG_Y_ENDS:      y_ends_q      <= cfg_data_i;
        REG_ANGLE_ENDS:  angle_ends_q  <= cfg_data_i;
        REG_START_SCALE: start_scale_q <= cfg_data_i[31:0];
        REG_PEAK_SCALE:  peak_scale_q  <= cfg_data_i[31:0];
        REG_END_SCALE:   end_scale_q   <= cfg_data_i[31:0];
        REG_DURATION:    duration_q    <= cfg_data_i[DurW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, elapsed time and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      elapsed_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        elapsed_q <= el_new;
      end
      if (state_q == S_PREP) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_PREP: begin
        fin_q <= (elapsed_q > {1'b0, dur_eff});
        rem_q <= elapsed_q;
        quo_q <= '0;
      end
      S_DIV: begin
        rem_q <= {div_rn[ElapsedW-2:0], 1'b0};
        quo_q <= {quo_q[15:0], div_ge};
      end
      S_EASE: e_q  <= ONE_Q16 - mres[16:0];
      S_LY:   px_q <= lerp_sum[31:0];
      S_LA:   py_q <= lerp_sum[31:0];
      S_LS:   pa_q <= lerp_sum[31:0];
      S_OUT: begin
        if (out_free) begin
          out_data_q <= {7'd0, e_q, pa_q, lerp_sum[31:0], py_q, px_q};
          out_user_q <= {(angle_ends_q[31:0] != angle_ends_q[63:32]), fin_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Accepted request starts the sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_PREP))
    else $error("accepted request did not start the sequence");

  // Eased progress never exceeds one
  a_eased_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[144:128] <= ONE_Q16))
    else $error("eased_t out of range");

  // Finished results carry full progress
  a_fin_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[144:128] == ONE_Q16))
    else $error("finished result without full progress");

  // Divider runs exactly its quotient length
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ1) |-> ($past(state_q) == S_DIV && $past(cnt_q) == DIV_LAST))
    else $error("divider left early or late");

endmodule

`default_nettype wire

[hdl/evi_mul_unit.sv]
// Shared signed multiplier with Q16 rounding: res = floor((a*b + 32768) / 65536).
// Depends on evi_pkg for the request struct and widths.
`default_nettype none

module evi_mul_unit (
  input  wire logic                            clk_i,
  input  wire evi_pkg::mul_req_t               req_i,
  output logic signed [evi_pkg::MulAW-1:0]     res_o
);
  import evi_pkg::*;

  logic signed [MulProdW-1:0] prod;
  logic signed [MulProdW-1:0] rnd;
  logic signed [MulAW-1:0]    res_q;

  // Multiply and add half an LSB of the Q16 result
  always_comb begin
    prod = req_i.op_a * req_i.op_b;
    rnd  = prod + MulProdW'(32768);
  end

  // Register the arithmetic-shifted result
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      res_q <= rnd[MulAW+15:16];
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[test/eased_view_interpolator_unit_tb.sv]
// Self-checking testbench for eased_view_interpolator_unit: a scoreboard class predicts every
// frame from its own copy of the registers and elapsed time; plain tasks drive requests.
// Depends on evi_pkg (register indexes, reset values) and the unit itself.
`default_nettype none

typedef enum bit {
  OP_ADVANCE = 1'b0,
  OP_FINISH  = 1'b1
} view_op_e;

// Result tdata layout, lowest field last
typedef struct packed {
  logic [6:0]  pad;
  logic [16:0] eased_t;
  logic [31:0] cur_angle;
  logic [31:0] cur_scale;
  logic [31:0] pos_y;
  logic [31:0] pos_x;
} view_data_t;

typedef struct packed {
  logic angle_valid;
  logic finished;
} view_flags_t;

typedef struct packed {
  view_flags_t flags;
  view_data_t  data;
} view_frame_t;

class eased_view_scoreboard;
  logic [63:0]  x_ends;
  logic [63:0]  y_ends;
  logic [63:0]  angle_ends;
  logic [31:0]  start_scale;
  logic [31:0]  peak_scale;
  logic [31:0]  end_scale;
  logic [23:0]  duration;
  longint       elapsed;
  view_frame_t  frames_due[$];
  int           errors;

  function new();
    x_ends      = '0;
    y_ends      = '0;
    angle_ends  = '0;
    start_scale = 32'h0001_0000;
    peak_scale  = 32'h0001_0000;
    end_scale   = 32'h0001_0000;
    duration    = evi_pkg::DUR_RESET;
    elapsed     = 0;
    errors      = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] data);
    case (idx)
      evi_pkg::REG_X_ENDS:      x_ends = data;
      evi_pkg::REG_Y_ENDS:      y_ends = data;
      evi_pkg::REG_ANGLE_ENDS:  angle_ends = data;
      evi_pkg::REG_START_SCALE: start_scale = data[31:0];
      evi_pkg::REG_PEAK_SCALE:  peak_scale = data[31:0];
      evi_pkg::REG_END_SCALE:   end_scale = data[31:0];
      evi_pkg::REG_DURATION:    duration = data[23:0];
      default: ;
    endcase
  endfunction

  // a + round((b - a) * f / 2^16); the arithmetic shift floors, so the result stays in [a, b]
  function longint blend_q16(longint a, longint b, longint f);
    return a + (((b - a) * f + 32768) >>> 16);
  endfunction

  function int pending();
    return frames_due.size();
  endfunction

  // Advance elapsed time for one request and queue the frame it must produce
  function void note_step(view_op_e op, logic [19:0] delta);
    longint      span;
    longint      t;
    longint      u;
    longint      u2;
    longint      u4;
    longint      e;
    longint      lo;
    longint      hi;
    view_frame_t f;
    span = (duration == 0) ? 1 : duration;
    if (op == OP_FINISH) begin
      elapsed = span + 1;
    end else begin
      elapsed = elapsed + delta;
      if (elapsed > longint'(evi_pkg::ELAPSED_MAX)) elapsed = evi_pkg::ELAPSED_MAX;
    end
    f = '0;
    f.flags.finished = (elapsed > span);
    // quartic ease-out of t = elapsed / span
    if (f.flags.finished) begin
      e = 65536;
    end else begin
      t  = (elapsed << 16) / span;
      u  = 65536 - t;
      u2 = (u * u + 32768) >> 16;
      u4 = (u2 * u2 + 32768) >> 16;
      e  = 65536 - u4;
    end
    lo = $signed(x_ends[31:0]);
    hi = $signed(x_ends[63:32]);
    f.data.pos_x = 32'(blend_q16(lo, hi, e));
    lo = $signed(y_ends[31:0]);
    hi = $signed(y_ends[63:32]);
    f.data.pos_y = 32'(blend_q16(lo, hi, e));
    lo = $signed(angle_ends[31:0]);
    hi = $signed(angle_ends[63:32]);
    f.data.cur_angle = 32'(blend_q16(lo, hi, e));
    // scale climbs to the peak over the first eased half, then heads for the end value
    if (e <= 32768) f.data.cur_scale = 32'(blend_q16(start_scale, peak_scale, 2 * e));
    else f.data.cur_scale = 32'(blend_q16(peak_scale, end_scale, 2 * (e - 32768)));
    f.data.eased_t = 17'(e);
    f.flags.angle_valid = (angle_ends[31:0] != angle_ends[63:32]);
    frames_due.push_back(f);
  endfunction

  // Compare one accepted result with the oldest queued frame
  function void check_frame(view_frame_t got);
    view_frame_t want;
    logic [31:0] want_v[7];
    logic [31:0] got_v[7];
    string       names[7];
    int          i;
    if (frames_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result with no request pending: %h", got);
      return;
    end
    want = frames_due.pop_front();
    names = '{"pos_x", "pos_y", "cur_scale", "cur_angle", "eased_t", "finished",
              "angle_valid"};
    want_v = '{want.data.pos_x, want.data.pos_y, want.data.cur_scale, want.data.cur_angle,
               32'(want.data.eased_t), 32'(want.flags.finished),
               32'(want.flags.angle_valid)};
    got_v = '{got.data.pos_x, got.data.pos_y, got.data.cur_scale, got.data.cur_angle,
              32'(got.data.eased_t), 32'(got.flags.finished), 32'(got.flags.angle_valid)};
    for (i = 0; i < 7; i++) begin
      if (want_v[i] !== got_v[i]) begin
        errors++;
        if (errors <= 10)
          $display("%s mismatch: expected %h, actual %h", names[i], want_v[i], got_v[i]);
      end
    end
  endfunction
endclass

module eased_view_interpolator_unit_tb;

  localparam logic [2:0] REG_SPARE   = 3'd7;  // no register behind this index
  localparam int         CycleLimit  = 1_000_000;
  localparam int         DrainCycles = 40;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [23:0]  s_axis_tdata_i = '0;   // delta_us[19:0], zero pad
  logic [0:0]   s_axis_tuser_i = '0;   // opcode[0]
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // pos_x[31:0], pos_y[63:32], cur_scale[95:64], cur_angle[127:96], eased_t[144:128], pad
  logic [151:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;        // finished[0], angle_valid[1]

  eased_view_scoreboard board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int steps_sent = 0;
  int cycle_count = 0;

  eased_view_interpolator_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Track register writes, accepted requests and accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) board.write_reg(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o)
        board.note_step(view_op_e'(s_axis_tuser_i[0]), s_axis_tdata_i[19:0]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        board.check_frame(view_frame_t'({m_axis_tuser_o, m_axis_tdata_o}));
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("eased_view_interpolator_unit verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Upper bits are junk that the register must drop
  task automatic write_duration(logic [23:0] span);
    write_reg(evi_pkg::REG_DURATION, {$urandom, 8'($urandom), span});
  endtask

  task automatic send_step(view_op_e op, logic [19:0] delta);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {4'b0, delta};
    do @(posedge clk_i); while (!s_axis_tready_o);
    steps_sent++;
  endtask

  // Drop the request lines and hold until every frame is back
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    cfg_we_i        <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_duration();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'($urandom_range(64, 1));
      2: return 24'hFF_FFFF;
      3: return 24'($urandom_range(1000, 1));
      default: return 24'($urandom_range(4_000_000, 1000));
    endcase
  endfunction

  // One animation: new endpoints, rewind elapsed time, then a run of time steps
  task automatic run_animation(bit saturate);
    int unsigned stride;
    int unsigned steps;
    int unsigned k;
    logic [31:0] angle_lo;
    logic [23:0] span;
    wait_idle();
    if ($urandom_range(1)) write_reg(evi_pkg::REG_X_ENDS, {pick_q16(), pick_q16()});
    if ($urandom_range(1)) write_reg(evi_pkg::REG_Y_ENDS, {pick_q16(), pick_q16()});
    if ($urandom_range(1)) begin
      angle_lo = pick_q16();
      write_reg(evi_pkg::REG_ANGLE_ENDS,
                {($urandom_range(3) == 0) ? angle_lo : pick_q16(), angle_lo});
    end
    if ($urandom_range(1)) write_reg(evi_pkg::REG_START_SCALE, {$urandom, pick_q16()});
    if ($urandom_range(1)) write_reg(evi_pkg::REG_PEAK_SCALE, {$urandom, pick_q16()});
    if ($urandom_range(1)) write_reg(evi_pkg::REG_END_SCALE, {$urandom, pick_q16()});
    if ($urandom_range(7) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
    // finishing under a one-microsecond duration leaves elapsed at two
    write_duration(24'd0);
    send_step(OP_FINISH, 20'($urandom));
    wait_idle();
    span = pick_duration();
    write_duration(span);
    stride = span / $urandom_range(30, 3);
    if (stride == 0) stride = 1;
    if (stride > 20'hFFFFF) stride = 20'hFFFFF;
    steps = saturate ? 40 : $urandom_range(40, 10);
    repeat (steps) begin
      k = $urandom_range(99);
      if (saturate) begin
        send_step(OP_ADVANCE, 20'hFFFFF);
      end else if (k < 3) begin
        send_step(OP_FINISH, 20'($urandom));
      end else if (k < 6) begin
        send_step(OP_ADVANCE, 20'($urandom));
      end else if (k < 8) begin
        send_step(OP_ADVANCE, 20'd0);
      end else if (k < 10) begin
        // change the length mid-run; elapsed time is kept
        wait_idle();
        span = pick_duration();
        write_duration(span);
      end else begin
        send_step(OP_ADVANCE, 20'($urandom_range(stride + stride / 2, stride / 2)));
      end
    end
  endtask

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    int budget;
    int p;
    idle_plan  = '{0, 59, 0, 29};
    stall_plan = '{0, 0, 59, 29};
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: start and midpoint of the default animation
    send_step(OP_ADVANCE, 20'd0);
    send_step(OP_ADVANCE, 20'd250000);
    wait_idle();
    // extreme endpoints, equal angles, scale peaking at full range
    write_reg(evi_pkg::REG_X_ENDS, 64'h7FFF_FFFF_8000_0000);
    write_reg(evi_pkg::REG_Y_ENDS, 64'h8000_0000_7FFF_FFFF);
    write_reg(evi_pkg::REG_ANGLE_ENDS, 64'h1234_5678_1234_5678);
    write_reg(evi_pkg::REG_START_SCALE, 64'h0);
    write_reg(evi_pkg::REG_PEAK_SCALE, 64'hFFFF_FFFF);
    write_reg(evi_pkg::REG_END_SCALE, 64'h0);
    write_reg(evi_pkg::REG_DURATION, 64'h0);
    write_reg(REG_SPARE, '1);
    // zero duration counts as one microsecond; finish ignores its delta
    send_step(OP_FINISH, 20'hFFFFF);
    send_step(OP_ADVANCE, 20'd0);
    wait_idle();
    // lengthen mid-run: elapsed equal to the length is not yet finished
    write_reg(evi_pkg::REG_DURATION, 64'd2);
    send_step(OP_ADVANCE, 20'd0);
    wait_idle();
    write_reg(evi_pkg::REG_DURATION, 64'd4);
    send_step(OP_ADVANCE, 20'd0);
    wait_idle();
    // full-range angle and longest duration, then run past the end
    write_reg(evi_pkg::REG_ANGLE_ENDS, 64'h7FFF_FFFF_8000_0000);
    write_reg(evi_pkg::REG_DURATION, 64'hFF_FFFF);
    send_step(OP_ADVANCE, 20'd0);
    repeat (3) send_step(OP_ADVANCE, 20'hFFFFF);
    send_step(OP_ADVANCE, 20'd1);
    send_step(OP_FINISH, 20'd0);
    send_step(OP_ADVANCE, 20'hFFFFF);
    wait_idle();
    // short animation in 16-microsecond steps
    write_reg(evi_pkg::REG_DURATION, 64'd0);
    send_step(OP_FINISH, 20'd0);
    wait_idle();
    write_reg(evi_pkg::REG_DURATION, 64'd64);
    repeat (4) send_step(OP_ADVANCE, 20'd16);

    // random animations under each idling pattern
    for (p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      budget = steps_sent + 375;
      while (steps_sent < budget) run_animation($urandom_range(11) == 0);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("eased_view_interpolator_unit verification clean");
    end else begin
      $display("eased_view_interpolator_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/evi_pkg.sv
hdl/evi_mul_unit.sv
hdl/eased_view_interpolator_unit.sv
test/eased_view_interpolator_unit_tb.sv
